/* rtl/core/fpml_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpml_pkg
// Shared types and constants of the FASTA pattern match locator.
// ----------------------------------------------------------------------------
package fpml_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int WORD_COUNT = 4;
    localparam int PAT_BYTES  = WORD_COUNT * WORD_W / BYTE_W;
    localparam int PAT_IDX_W  = $clog2(PAT_BYTES);
    localparam int CFG_LEN_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int COUNT_W    = 32;

    localparam logic [BYTE_W-1:0]  HEADER_MARK  = 8'h3E;
    localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'h0A;
    localparam logic [COUNT_W-1:0] POS_MAX      = 32'hFFFF_FFFF;

    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_bytes_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD_0 = 3'd1,
        REG_PATTERN_WORD_1 = 3'd2,
        REG_PATTERN_WORD_2 = 3'd3,
        REG_PATTERN_WORD_3 = 3'd4
    } cfg_reg_t;

endpackage
`default_nettype wire

/* rtl/core/fpml_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpml_cell
// One window cell: holds one stream byte, passes it on to the next cell and
// compares it against the pattern byte that lines up with its slot.
// ----------------------------------------------------------------------------
module fpml_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 6
) (
    input  wire logic                          clk,
    input  wire logic                          shift_en,
    input  wire logic [fpml_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic [LEN_W-1:0]              eff_len,
    input  wire fpml_pkg::pat_bytes_t          pattern,
    output logic      [fpml_pkg::BYTE_W-1:0]   byte_out,
    output logic                               match
);

    localparam int PIDX_W = (LEN_W > fpml_pkg::PAT_IDX_W + 1) ? LEN_W
                                                              : fpml_pkg::PAT_IDX_W + 1;

    logic [fpml_pkg::BYTE_W-1:0] win_reg;
    logic [fpml_pkg::BYTE_W-1:0] win_next;
    logic [PIDX_W-1:0]           len_ext;
    logic [PIDX_W-1:0]           pidx;
    logic                        active;
    logic [fpml_pkg::BYTE_W-1:0] pat_byte;

    assign win_next = shift_en ? byte_in : win_reg;

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    // Slot INDEX holds the byte that must equal pattern byte len-1-INDEX.
    always_comb
    begin
        len_ext = PIDX_W'(eff_len);
        active  = len_ext > PIDX_W'(INDEX);
        pidx    = len_ext - PIDX_W'(1) - PIDX_W'(INDEX);
        if (pidx < PIDX_W'(fpml_pkg::PAT_BYTES))
            pat_byte = pattern[pidx[fpml_pkg::PAT_IDX_W-1:0]];
        else
            pat_byte = '0;
        match = !active || (win_reg == pat_byte);
    end

    assign byte_out = win_reg;

endmodule
`default_nettype wire

/* rtl/core/fasta_pattern_match_locator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fasta_pattern_match_locator_top
// Exact pattern search over a multi-FASTA byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one raw stream byte per transfer. A '>' opens a
//   new record and header mode, which ends at the next newline. Every other byte
//   outside a header is a sequence byte and shifts into a row of MAX_PATTERN
//   cells, the newest byte in cell 0. When enough bytes of the record are in
//   and every active cell agrees with the pattern, one m_ transfer reports
//   the match. The pattern and its length are set through the cfg_ write port
//   while the stream is idle.
// Throughput:
//   One byte per cycle while s_tready is high. The cell row is compared in the
//   cycle after a byte is taken and a match is registered to drive m_tvalid.
// Reset:
//   Header mode, record and position counters at zero, pattern length one,
//   pattern words zero. No clearing pass is needed.
// Stalls:
//   The output register waits for m_tready. s_tready drops only while a
//   comparison is pending and the output register still holds an untaken
//   result.
// ----------------------------------------------------------------------------
module fasta_pattern_match_locator_top #(
    parameter int MAX_PATTERN = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Stream input.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] symbol
    // Match results.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [95:0]                           m_tdata,   // [31:0] match_start,
                                                             // [63:32] match_end,
                                                             // [95:64] record_number
    // Configuration write port.
    input  wire logic                             cfg_we,
    input  wire logic [fpml_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fpml_pkg::WORD_W-1:0]      cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CW    = fpml_pkg::COUNT_W;

    // Configuration registers.
    logic [fpml_pkg::CFG_LEN_W-1:0] len_reg;
    logic [fpml_pkg::WORD_W-1:0]    word0_reg, word1_reg, word2_reg, word3_reg;
    fpml_pkg::pat_bytes_t           pattern;
    logic [fpml_pkg::CFG_LEN_W:0]   len_wide;
    logic [LEN_W-1:0]               eff_len;

    // Stream state.
    logic          in_header_reg, in_header_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] rec_reg, rec_next;
    logic          eval_valid_reg, eval_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] start_reg, end_reg, recnum_reg;

    logic          accept;
    logic          is_mark;
    logic          is_seq;
    logic [CW-1:0] pos_inc;
    logic          seq_eval;
    logic          stall;
    logic          hit;
    logic          load_out;

    logic [MAX_PATTERN-1:0]                      cell_match;
    logic [MAX_PATTERN:0][fpml_pkg::BYTE_W-1:0]  chain;

    // ------------------------------------------------------------------
    // Configuration.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= fpml_pkg::CFG_LEN_W'(1);
            word0_reg <= '0;
            word1_reg <= '0;
            word2_reg <= '0;
            word3_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (fpml_pkg::cfg_reg_t'(cfg_index))
                fpml_pkg::REG_PATTERN_LENGTH: len_reg   <= cfg_data[fpml_pkg::CFG_LEN_W-1:0];
                fpml_pkg::REG_PATTERN_WORD_0: word0_reg <= cfg_data;
                fpml_pkg::REG_PATTERN_WORD_1: word1_reg <= cfg_data;
                fpml_pkg::REG_PATTERN_WORD_2: word2_reg <= cfg_data;
                fpml_pkg::REG_PATTERN_WORD_3: word3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pattern  = {word3_reg, word2_reg, word1_reg, word0_reg};
    assign len_wide = {1'b0, len_reg};

    // A length of zero acts as one, a length above the cell count as the cell count.
    always_comb
    begin
        priority if (len_reg == '0)
            eff_len = LEN_W'(1);
        else if (len_wide > (fpml_pkg::CFG_LEN_W + 1)'(MAX_PATTERN))
            eff_len = LEN_W'(MAX_PATTERN);
        else
            eff_len = LEN_W'(len_reg);
    end

    // ------------------------------------------------------------------
    // Stream control.
    // ------------------------------------------------------------------
    assign stall    = eval_valid_reg && out_valid_reg && !m_tready;
    assign s_tready = !stall;
    assign accept   = s_tvalid && s_tready;
    assign is_mark  = (s_tdata == fpml_pkg::HEADER_MARK);
    assign is_seq   = !is_mark && !in_header_reg;
    assign pos_inc  = (pos_reg == fpml_pkg::POS_MAX) ? pos_reg : pos_reg + CW'(1);
    assign seq_eval = is_seq && (pos_inc >= CW'(eff_len));

    always_comb
    begin
        in_header_next = in_header_reg;
        pos_next       = pos_reg;
        rec_next       = rec_reg;
        if (accept)
        begin
            priority if (is_mark)
            begin
                rec_next       = rec_reg + CW'(1);
                pos_next       = '0;
                in_header_next = 1'b1;
            end
            else if (in_header_reg)
            begin
                if (s_tdata == fpml_pkg::NEWLINE_BYTE)
                    in_header_next = 1'b0;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
    end

    always_comb
    begin
        priority if (accept)
            eval_valid_next = seq_eval;
        else if (stall)
            eval_valid_next = eval_valid_reg;
        else
            eval_valid_next = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cell row.
    // ------------------------------------------------------------------
    assign chain[0] = s_tdata;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        fpml_cell #(
            .INDEX (i),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk      (clk),
            .shift_en (accept && is_seq),
            .byte_in  (chain[i]),
            .eff_len  (eff_len),
            .pattern  (pattern),
            .byte_out (chain[i+1]),
            .match    (cell_match[i])
        );
    end

    assign hit      = &cell_match;
    assign load_out = eval_valid_reg && !stall && hit;

    always_comb
    begin
        priority if (load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg  <= 1'b1;
            pos_reg        <= '0;
            rec_reg        <= '0;
            eval_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_header_reg  <= in_header_next;
            pos_reg        <= pos_next;
            rec_reg        <= rec_next;
            eval_valid_reg <= eval_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // While a comparison is pending the counters still describe its byte.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            start_reg  <= pos_reg - CW'(eff_len) + CW'(1);
            end_reg    <= pos_reg;
            recnum_reg <= rec_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {recnum_reg, end_reg, start_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_eval_counters: assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid_reg |-> !in_header_reg && (pos_reg >= CW'(eff_len)))
        else $error("pending comparison without enough sequence bytes");

    a_mark_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_mark) |=> in_header_reg && (pos_reg == '0) && !eval_valid_reg)
        else $error("header marker did not restart the record");

    a_seq_position: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_seq) |=> (pos_reg != '0))
        else $error("sequence byte did not advance the position");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> eval_valid_reg && out_valid_reg)
        else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
